### hw/rtl/tbrl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the token bucket rate limiter.
// Depends on nothing; every other file in hw/rtl imports it.
package tbrl_pkg;

  // Width of the data path and of the configuration registers.
  localparam int unsigned DataW = 32;
  // Width at which time values are held, limited to the input field width.
  localparam int unsigned TimeWidth = 32;
  localparam int unsigned TimeW = (TimeWidth < DataW) ? TimeWidth : DataW;
  // Divider step counter, wide enough to hold DataW itself.
  localparam int unsigned CntW = $clog2(DataW + 1);

  // Register file: three 32-bit registers at byte addresses 0, 4 and 8.
  localparam int unsigned AddrW = 4;
  localparam int unsigned RegIdxW = AddrW - 2;
  localparam logic [RegIdxW-1:0] RegPeriod = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] RegBurst = RegIdxW'(1);
  localparam logic [RegIdxW-1:0] RegAmount = RegIdxW'(2);

  // Item actions.
  localparam logic ActInit = 1'b0;
  localparam logic ActRequest = 1'b1;

  typedef struct packed {
    logic action;
    logic [DataW-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic granted;
    logic [DataW-1:0] tokens_left;
  } out_item_t;

  typedef struct packed {
    logic [DataW-1:0] refill_period;
    logic [DataW-1:0] burst_limit;
    logic [DataW-1:0] refill_amount;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StMul,
    StCap,
    StEmit
  } state_e;

endpackage

### hw/rtl/token_bucket_rate_limiter.sv
`timescale 1ns / 1ps
// Single token bucket rate limiter: sequencer, bucket state and result register.
// Depends on tbrl_pkg, tbrl_regs and tbrl_div.
//
// Usage:
//   Items enter on in_valid_i/in_ready_o with in_item_i (action, now); each
//   item gives exactly one result on out_valid_o/out_ready_i (granted,
//   tokens_left). An init item empties the bucket and stamps the time. A
//   request takes a token if one is held, otherwise refills by the whole
//   periods elapsed, if any, and then tries again.
//   The three registers (refill_period, burst_limit, refill_amount) sit at
//   byte addresses 0, 4 and 8 of the APB-style port; write them only while
//   the block is idle. pready is tied high.
// Sequence:
//   Init, direct take, same-time, zero-period and time-before-stamp items
//   go from acceptance straight to result load. A refill runs the 32-step
//   divider, then multiply, cap and result load. A new item is accepted
//   only once the sequencer has returned to idle.
// Reset:
//   rst_ni clears the bucket (count, stamp and last evaluation time all
//   zero), sets all three registers to one and empties the result register.
// Stall:
//   A finished result waits in the output register while the next item is
//   accepted; a second result waits in the sequencer until the first is taken.
module token_bucket_rate_limiter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tbrl_pkg::in_item_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tbrl_pkg::out_item_t          out_item_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tbrl_pkg::AddrW-1:0]   paddr,
  input  logic [tbrl_pkg::DataW-1:0]   pwdata,
  output logic [tbrl_pkg::DataW-1:0]   prdata,
  output logic                         pready
);
  import tbrl_pkg::*;

  cfg_t cfg;
  div_status_t div_st;
  logic [DataW-1:0] div_quot, div_rem;
  logic div_start;
  logic [DataW-1:0] div_dividend;

  state_e state_q, state_d;
  logic [DataW-1:0] token_q, token_d;
  logic [TimeW-1:0] stamp_q, stamp_d;
  logic [TimeW-1:0] last_q, last_d;
  logic [TimeW-1:0] now_q, now_d;
  logic [2*DataW-1:0] prod_q, prod_d;
  out_item_t res_q, res_d;
  out_item_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic [TimeW-1:0] now_t;
  logic [DataW-1:0] capped;
  logic accept, out_free;

  tbrl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tbrl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cfg.refill_period),
    .status_o   (div_st),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Hold time at the bucket's time width.
  assign now_t = in_item_i.now[TimeW-1:0];
  assign div_dividend = DataW'(now_t - stamp_q);

  assign in_ready_o = (state_q == StIdle);
  assign accept = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;

  // Cap the refill at the burst limit; the count was empty, so no carry-in.
  assign capped = (prod_q > (2*DataW)'(cfg.burst_limit)) ? cfg.burst_limit
                                                          : prod_q[DataW-1:0];

  always_comb begin
    state_d = state_q;
    token_d = token_q;
    stamp_d = stamp_q;
    last_d = last_q;
    now_d = now_q;
    prod_d = prod_q;
    res_d = res_q;
    div_start = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          now_d = now_t;
          res_d.granted = 1'b0;
          res_d.tokens_left = '0;
          state_d = StEmit;
          if (in_item_i.action == ActInit) begin
            last_d = now_t;
            stamp_d = now_t;
            token_d = '0;
          end else if (token_q != '0) begin
            // Take a token straight away, no refill.
            token_d = token_q - DataW'(1);
            res_d.granted = 1'b1;
            res_d.tokens_left = token_q - DataW'(1);
          end else if (last_q == now_t || cfg.refill_period == '0) begin
            // Same time, or a zero period: deny and leave the state alone.
            state_d = StEmit;
          end else if (now_t < stamp_q) begin
            // Time before the stamp: no periods, move the evaluation time only.
            last_d = now_t;
          end else begin
            div_start = 1'b1;
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        if (div_st.done) begin
          state_d = StMul;
        end
      end
      StMul: begin
        // Advance the stamp by whole periods: now minus the remainder.
        prod_d = (2*DataW)'(div_quot) * (2*DataW)'(cfg.refill_amount);
        stamp_d = now_q - div_rem[TimeW-1:0];
        last_d = now_q;
        state_d = StCap;
      end
      StCap: begin
        if (capped != '0) begin
          token_d = capped - DataW'(1);
          res_d.granted = 1'b1;
          res_d.tokens_left = capped - DataW'(1);
        end else begin
          token_d = '0;
          res_d.granted = 1'b0;
          res_d.tokens_left = '0;
        end
        state_d = StEmit;
      end
      StEmit: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Result register: load from the sequencer, drop once taken.
  always_comb begin
    out_d = out_q;
    out_valid_d = out_valid_q;
    if (state_q == StEmit && out_free) begin
      out_d = res_q;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      token_q <= '0;
      stamp_q <= '0;
      last_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      token_q <= token_d;
      stamp_q <= stamp_d;
      last_q <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    prod_q <= prod_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  // The divider only reports completion while the sequencer waits for it.
  a_div_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> state_q == StDiv)
    else $error("divider finished outside the divide state");

  // While waiting on the divider it must be running or just finished.
  a_div_alive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> div_st.busy || div_st.done)
    else $error("sequencer waits on an idle divider");

  // An accepted init item leaves the bucket empty.
  a_init_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_item_i.action == ActInit) |=> token_q == '0)
    else $error("init item did not empty the bucket");

endmodule

### hw/rtl/tbrl_regs.sv
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
// Depends on tbrl_pkg for the register map and the cfg_t bundle.
module tbrl_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tbrl_pkg::AddrW-1:0]   paddr,
  input  logic [tbrl_pkg::DataW-1:0]   pwdata,
  output logic [tbrl_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output tbrl_pkg::cfg_t               cfg_o
);
  import tbrl_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic [RegIdxW-1:0] reg_idx;
  logic wr_en;

  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegPeriod: cfg_d.refill_period = pwdata;
        RegBurst:  cfg_d.burst_limit = pwdata;
        RegAmount: cfg_d.refill_amount = pwdata;
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegPeriod: prdata = cfg_q.refill_period;
      RegBurst:  prdata = cfg_q.burst_limit;
      RegAmount: prdata = cfg_q.refill_amount;
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.refill_period <= DataW'(1);
      cfg_q.burst_limit <= DataW'(1);
      cfg_q.refill_amount <= DataW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### hw/rtl/tbrl_div.sv
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tbrl_pkg for widths and the status struct.
module tbrl_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tbrl_pkg::DataW-1:0] dividend_i,
  input  logic [tbrl_pkg::DataW-1:0] divisor_i,
  output tbrl_pkg::div_status_t      status_o,
  output logic [tbrl_pkg::DataW-1:0] quot_o,
  output logic [tbrl_pkg::DataW-1:0] rem_o
);
  import tbrl_pkg::*;

  logic [CntW-1:0] cnt_q;
  logic done_q;
  logic [DataW-1:0] rem_q, quot_q, divisor_q;
  logic [DataW:0] shifted, trial;

  // Shift in the next dividend bit and try a subtract; a set top bit means it borrowed.
  assign shifted = {rem_q, quot_q[DataW-1]};
  assign trial = shifted - {1'b0, divisor_q};

  assign status_o.busy = (cnt_q != '0);
  assign status_o.done = done_q;
  assign quot_o = quot_q;
  assign rem_o = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q <= CntW'(DataW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CntW'(1);
      done_q <= (cnt_q == CntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quot_q <= dividend_i;
      divisor_q <= divisor_i;
    end else if (cnt_q != '0) begin
      if (!trial[DataW]) begin
        rem_q <= trial[DataW-1:0];
        quot_q <= {quot_q[DataW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DataW-1:0];
        quot_q <= {quot_q[DataW-2:0], 1'b0};
      end
    end
  end

endmodule
